### src/alid_pkg.sv
// ----------------------------------------------------------------------------
// alid_pkg
// Types and codes shared by the array list insert/delete block.
// ----------------------------------------------------------------------------
package alid_pkg;

  localparam int unsigned PosW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_DEL_SHIFT,
    S_DUMP
  } state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [PosW-1:0]        position;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] elem_value;
    logic [CountW-1:0]       elem_count;
    logic                    last_of_run;
  } res_t;

endpackage

### src/alid_mem.sv
// ----------------------------------------------------------------------------
// alid_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alid_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [alid_pkg::DataW-1:0]        wr_data_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [alid_pkg::DataW-1:0]        rd_data_o
);
  import alid_pkg::*;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/alid_ctrl.sv
// ----------------------------------------------------------------------------
// alid_ctrl
// Request sequencer: checks each request, then walks the store one entry a
// cycle to shift for insert/delete or to emit entries for dump.
// ----------------------------------------------------------------------------
module alid_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  alid_pkg::req_t                    req_i,
  output logic                              busy_o,
  output logic                              mem_wr_en_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_wr_addr_o,
  output logic [alid_pkg::DataW-1:0]        mem_wr_data_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_rd_addr_o,
  input  logic [alid_pkg::DataW-1:0]        mem_rd_data_i,
  output logic                              res_valid_o,
  output alid_pkg::res_t                    res_o
);
  import alid_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > PosW) ? CW : PosW;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;

  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    pos_x;
  logic [XW-1:0]    idx_x;
  status_e          status;
  logic [DataW-1:0] out_value;
  logic             out_last;

  assign cnt_x = XW'(count_q);
  assign pos_x = XW'(req_i.position);
  assign idx_x = XW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    val_d         = val_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = idx_q;
    mem_wr_data_o = mem_rd_data_i;
    mem_rd_addr_o = '0;
    res_valid_o   = 1'b0;
    status        = ST_OK;
    out_value     = '0;
    out_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_valid_o = 1'b1;
          pos_d       = pos_x[AW-1:0];
          val_d       = req_i.value;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (cnt_x >= XW'(DEPTH)) begin
                status = ST_FULL;
              end else if (pos_x > cnt_x) begin
                status = ST_BADPOS;
              end else if (pos_x == cnt_x) begin
                // append: no shift needed
                mem_wr_en_o   = 1'b1;
                mem_wr_addr_o = pos_x[AW-1:0];
                mem_wr_data_o = req_i.value;
                count_d       = count_q + CW'(1);
              end else begin
                res_valid_o   = 1'b0;
                idx_d         = AW'(count_q);
                mem_rd_addr_o = AW'(count_q - CW'(1));
                state_d       = S_INS_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (count_q == '0) begin
                status = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status = ST_BADPOS;
              end else if (pos_x == cnt_x - XW'(1)) begin
                // tail entry: just drop it
                count_d = count_q - CW'(1);
              end else begin
                res_valid_o   = 1'b0;
                idx_d         = pos_x[AW-1:0];
                mem_rd_addr_o = AW'(pos_x + XW'(1));
                state_d       = S_DEL_SHIFT;
              end
            end
            REQ_DUMP: begin
              if (count_q == '0) begin
                status = ST_EMPTY;
              end else begin
                res_valid_o   = 1'b0;
                idx_d         = '0;
                mem_rd_addr_o = '0;
                state_d       = S_DUMP;
              end
            end
            default: begin
              status = ST_BADPOS;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // move entry idx-1 up into idx
        mem_wr_en_o = 1'b1;
        if (idx_q - AW'(1) == pos_q) begin
          state_d = S_INS_WRITE;
        end else begin
          idx_d         = idx_q - AW'(1);
          mem_rd_addr_o = idx_q - AW'(2);
        end
      end

      S_INS_WRITE: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = pos_q;
        mem_wr_data_o = val_q;
        count_d       = count_q + CW'(1);
        res_valid_o   = 1'b1;
        state_d       = S_IDLE;
      end

      S_DEL_SHIFT: begin
        // move entry idx+1 down into idx
        mem_wr_en_o = 1'b1;
        if (idx_x + XW'(2) == cnt_x) begin
          count_d     = count_q - CW'(1);
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d         = idx_q + AW'(1);
          mem_rd_addr_o = idx_q + AW'(2);
        end
      end

      S_DUMP: begin
        res_valid_o = 1'b1;
        out_value   = mem_rd_data_i;
        out_last    = (idx_x + XW'(1) == cnt_x);
        if (out_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d         = idx_q + AW'(1);
          mem_rd_addr_o = idx_q + AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    res_o.status      = status;
    res_o.elem_value  = $signed(out_value);
    res_o.elem_count  = CountW'(count_d);
    res_o.last_of_run = out_last;
  end

endmodule

### src/array_list_insert_delete.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Ordered list of up to DEPTH signed 32-bit entries with insert, delete and
// dump requests.
// ----------------------------------------------------------------------------
// Usage
//   A request beat is taken when start is high and busy is low. Each
//   result beat sits on res_o for one cycle with res_valid_o high; there is
//   no back-pressure, the receiver has to take every beat.
//   Results appear in the cycle after the sequencer produces them (output
//   register). Rejected requests, appends, tail deletes and empty dumps
//   finish in the accept cycle, so busy stays low and a new request may
//   follow in the next cycle.
//   Insert at p shifts entries p and up one place up, delete at p shifts the
//   entries above p down; both hold busy and end in one result beat. Dump
//   holds busy and sends one result beat a cycle, last_of_run on the final.
//   The single write port of the entry store moves one entry a cycle.
//   Reset empties the list at once; entry contents are not cleared and are
//   never read before being written.
// ----------------------------------------------------------------------------
module array_list_insert_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  alid_pkg::req_t req_i,
  output logic           busy,
  output logic           res_valid_o,
  output alid_pkg::res_t res_o
);
  import alid_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [DataW-1:0] mem_wr_data;
  logic [AW-1:0]    mem_rd_addr;
  logic [DataW-1:0] mem_rd_data;
  logic             res_valid_d, res_valid_q;
  res_t             res_d, res_q;

  alid_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  alid_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req_i),
    .busy_o        (busy),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .res_valid_o   (res_valid_d),
    .res_o         (res_d)
  );

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a dump run is never broken up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_of_run |=> res_valid_o)
    else $error("dump run interrupted");

  // while a dump run is still going the sequencer must stay busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_of_run |-> busy)
    else $error("busy dropped inside dump run");

  // non-ok results are single beats with no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_OK |-> res_o.last_of_run && res_o.elem_value == '0)
    else $error("bad error result");

  // an accepted request either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("request lost");

endmodule
